// ===== rtl/core/mac_pkg.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate unit package
// Operation codes and the decoded command that passes from front to back.
// ----------------------------------------------------------------------------
package mac_pkg;

    localparam logic [2:0] OP_MUL   = 3'd0;
    localparam logic [2:0] OP_MLA   = 3'd1;
    localparam logic [2:0] OP_UMULL = 3'd2;
    localparam logic [2:0] OP_SMULL = 3'd3;
    localparam logic [2:0] OP_UMLAL = 3'd4;
    localparam logic [2:0] OP_SMLAL = 3'd5;

    localparam logic [2:0] CYCLES_MIN = 3'd1;
    localparam logic [2:0] CYCLES_MAX = 3'd5;

    typedef struct packed {
        logic        is_long;
        logic        is_signed;
        logic        add_low;
        logic        add_high;
        logic        set_flags;
        logic [2:0]  cycles;
        logic [31:0] multiplicand;
        logic [31:0] multiplier;
        logic [31:0] addend_low;
        logic [31:0] addend_high;
    } t_mac_cmd;

endpackage

// ===== rtl/core/mac_if.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate channel interfaces
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mac_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic        set_flags;
    logic [31:0] multiplicand;
    logic [31:0] multiplier;
    logic [31:0] addend_low;
    logic [31:0] addend_high;

    modport source (
        output valid, op, set_flags, multiplicand, multiplier, addend_low, addend_high,
        input  ready
    );
    modport sink (
        input  valid, op, set_flags, multiplicand, multiplier, addend_low, addend_high,
        output ready
    );
endinterface

interface mac_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] product_low;
    logic [31:0] product_high;
    logic        writes_high;
    logic        flags_valid;
    logic        negative_flag;
    logic        zero_flag;
    logic [2:0]  cycles;

    modport source (
        output valid, product_low, product_high, writes_high, flags_valid,
               negative_flag, zero_flag, cycles,
        input  ready
    );
    modport sink (
        input  valid, product_low, product_high, writes_high, flags_valid,
               negative_flag, zero_flag, cycles,
        output ready
    );
endinterface

// ===== rtl/core/multiply_accumulate_unit.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate unit
// Execute-stage multiplier for 32-bit and 64-bit multiply and accumulate.
// ----------------------------------------------------------------------------
// The unit takes one request beat per cycle, except while the decode register
// holds a command that the full queue cannot take, and returns one response
// beat per request, in order. A request passes a decode register, a command
// queue of QUEUE_DEPTH entries and a two-stage multiply and accumulate
// pipeline; the multiplier stage bounds the clock. The cycles field reports
// the early-termination count of the multiplier operand for the execute stage.
module multiply_accumulate_unit
    import mac_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    mac_req_if.sink   i_req,
    mac_rsp_if.source o_rsp
);

    logic     push;
    logic     full;
    logic     pop;
    logic     empty;
    t_mac_cmd front_cmd;
    t_mac_cmd queue_cmd;

    mac_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_push  (push),
        .o_cmd   (front_cmd),
        .i_full  (full)
    );

    mac_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (queue_cmd)
    );

    mac_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_cmd   (queue_cmd),
        .o_pop   (pop),
        .o_rsp   (o_rsp)
    );

    a_high_zero_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.writes_high |-> o_rsp.product_high == 32'd0)
        else $error("Short operation returned a nonzero high word.");

    a_flags_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.flags_valid |-> !o_rsp.negative_flag && !o_rsp.zero_flag)
        else $error("Flags raised without a flag update.");

    a_cycles_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> o_rsp.cycles >= CYCLES_MIN && o_rsp.cycles <= CYCLES_MAX)
        else $error("Cycle count out of range.");

    a_mla_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.cycles == CYCLES_MAX |-> !o_rsp.writes_high)
        else $error("Long operation reported the multiply-add cycle count.");

    a_neg_zero_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> !(o_rsp.negative_flag && o_rsp.zero_flag))
        else $error("Negative and zero flags both set.");

endmodule

// ===== rtl/core/mac_front.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate front end
// Accepts request beats, decodes the operation and the early-termination
// cycle count, and hands the decoded command to the queue.
// ----------------------------------------------------------------------------
module mac_front
    import mac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    mac_req_if.sink  i_req,
    output logic     o_push,
    output t_mac_cmd o_cmd,
    input  logic     i_full
);

    logic     r_valid;
    t_mac_cmd r_cmd;
    t_mac_cmd n_cmd;
    logic [2:0] op;
    logic [31:0] rs;
    logic [7:0] fill;
    logic [2:0] base_cycles;
    logic accept;

    assign o_push      = r_valid && !i_full;
    assign i_req.ready = !r_valid || !i_full;
    assign accept      = i_req.valid && i_req.ready;
    assign o_cmd       = r_cmd;

    always_comb begin
        op   = (i_req.op > OP_SMLAL) ? OP_MUL : i_req.op;
        rs   = i_req.multiplier;
        fill = {8{rs[31]}};
        if (rs[31:24] != fill) begin
            base_cycles = 3'd4;
        end else if (rs[23:16] != fill) begin
            base_cycles = 3'd3;
        end else if (rs[15:8] != fill) begin
            base_cycles = 3'd2;
        end else begin
            base_cycles = 3'd1;
        end
        n_cmd.is_long      = (op inside {OP_UMULL, OP_SMULL, OP_UMLAL, OP_SMLAL});
        n_cmd.is_signed    = (op inside {OP_SMULL, OP_SMLAL});
        n_cmd.add_low      = (op inside {OP_MLA, OP_UMLAL, OP_SMLAL});
        n_cmd.add_high     = (op inside {OP_UMLAL, OP_SMLAL});
        n_cmd.set_flags    = i_req.set_flags;
        n_cmd.cycles       = (op == OP_MLA) ? base_cycles + 3'd1 : base_cycles;
        n_cmd.multiplicand = i_req.multiplicand;
        n_cmd.multiplier   = rs;
        n_cmd.addend_low   = i_req.addend_low;
        n_cmd.addend_high  = i_req.addend_high;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ===== rtl/core/mac_queue.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate command queue
// Small first-in first-out buffer between the front end and the datapath.
// ----------------------------------------------------------------------------
module mac_queue
    import mac_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_mac_cmd i_cmd,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_empty,
    output t_mac_cmd o_cmd
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_mac_cmd        r_mem [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/core/mac_back.sv =====
// ----------------------------------------------------------------------------
// Multiply-accumulate datapath
// Two-stage pipeline: a 33x33 signed multiply, then the accumulate add
// with flag generation into the response register.
// ----------------------------------------------------------------------------
module mac_back
    import mac_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_empty,
    input  t_mac_cmd i_cmd,
    output logic     o_pop,
    mac_rsp_if.source o_rsp
);

    logic        advance;
    logic        r_m_valid;
    logic [63:0] r_m_prod;
    logic [63:0] r_m_acc;
    logic        r_m_long;
    logic        r_m_flags;
    logic [2:0]  r_m_cycles;
    logic signed [32:0] op_a;
    logic signed [32:0] op_b;
    logic signed [65:0] prod;
    logic [63:0] sum;

    logic        r_o_valid;
    logic [31:0] r_o_low;
    logic [31:0] r_o_high;
    logic        r_o_long;
    logic        r_o_flags;
    logic        r_o_neg;
    logic        r_o_zero;
    logic [2:0]  r_o_cycles;

    assign advance = !r_o_valid || o_rsp.ready;
    assign o_pop   = advance && !i_empty;

    assign op_a = {i_cmd.is_signed & i_cmd.multiplicand[31], i_cmd.multiplicand};
    assign op_b = {i_cmd.is_signed & i_cmd.multiplier[31], i_cmd.multiplier};
    assign prod = op_a * op_b;
    assign sum  = r_m_prod + r_m_acc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_m_valid <= !i_empty;
            r_o_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_m_prod   <= prod[63:0];
            r_m_acc    <= {i_cmd.add_high ? i_cmd.addend_high : 32'd0,
                           i_cmd.add_low ? i_cmd.addend_low : 32'd0};
            r_m_long   <= i_cmd.is_long;
            r_m_flags  <= i_cmd.set_flags;
            r_m_cycles <= i_cmd.cycles;

            r_o_low    <= sum[31:0];
            r_o_high   <= r_m_long ? sum[63:32] : 32'd0;
            r_o_long   <= r_m_long;
            r_o_flags  <= r_m_flags;
            r_o_neg    <= r_m_flags && (r_m_long ? sum[63] : sum[31]);
            r_o_zero   <= r_m_flags && (r_m_long ? (sum == 64'd0) : (sum[31:0] == 32'd0));
            r_o_cycles <= r_m_cycles;
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.product_low   = r_o_low;
    assign o_rsp.product_high  = r_o_high;
    assign o_rsp.writes_high   = r_o_long;
    assign o_rsp.flags_valid   = r_o_flags;
    assign o_rsp.negative_flag = r_o_neg;
    assign o_rsp.zero_flag     = r_o_zero;
    assign o_rsp.cycles        = r_o_cycles;

endmodule
